/* rtl/core/fxa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fxa_pkg;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_INC      = 4'd4,
      CMD_DEC      = 4'd5,
      CMD_FROM_INT = 4'd6,
      CMD_TO_INT   = 4'd7,
      CMD_COMPARE  = 4'd8
   } cmd_type;

   typedef struct packed {
      logic less;
      logic equal;
      logic greater;
      logic div_zero;
   } flags_type;

endpackage
`default_nettype wire

/* rtl/core/fxa_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module fxa_front import fxa_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic [3:0]           command,
   input  wire logic signed [31:0]   operand_a,
   input  wire logic signed [31:0]   operand_b,
   output logic                      valid_ff,
   output cmd_type                   cmd_ff,
   output logic                      neg_ff,
   output logic [WORD_BITS-1:0]      res_ff,
   output flags_type                 flags_ff,
   output logic [WORD_BITS-1:0]      mag_a_ff,
   output logic [WORD_BITS-1:0]      mag_b_ff
);

   logic signed [WORD_BITS-1:0] a_w;
   logic signed [WORD_BITS-1:0] b_w;
   logic [WORD_BITS-1:0]        mag_a_in;
   logic [WORD_BITS-1:0]        mag_b_in;
   logic [WORD_BITS-1:0]        trunc_mag;
   logic [WORD_BITS-1:0]        res_in;
   flags_type                   flags_in;
   cmd_type                     cmd_in;

   assign a_w    = WORD_BITS'(operand_a);
   assign b_w    = WORD_BITS'(operand_b);
   assign cmd_in = cmd_type'(command);

   assign mag_a_in  = a_w[WORD_BITS-1] ? (~a_w + 1'b1) : a_w;
   assign mag_b_in  = b_w[WORD_BITS-1] ? (~b_w + 1'b1) : b_w;
   assign trunc_mag = mag_a_in >> FRAC_BITS;

   always_comb begin
      res_in   = '0;
      flags_in = '0;
      case (cmd_in)
         CMD_ADD:      res_in = a_w + b_w;
         CMD_SUB:      res_in = a_w - b_w;
         CMD_INC:      res_in = a_w + 1'b1;
         CMD_DEC:      res_in = a_w - 1'b1;
         CMD_FROM_INT: res_in = a_w << FRAC_BITS;
         CMD_TO_INT:   res_in = a_w[WORD_BITS-1] ? (~trunc_mag + 1'b1) : trunc_mag;
         CMD_DIV:      flags_in.div_zero = (b_w == '0);
         CMD_COMPARE: begin
            flags_in.less    = a_w < b_w;
            flags_in.equal   = a_w == b_w;
            flags_in.greater = a_w > b_w;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff   <= cmd_in;
         neg_ff   <= a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
         res_ff   <= res_in;
         flags_ff <= flags_in;
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/fxa_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module fxa_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic [WORD_BITS-1:0] mag_a,
   input  wire logic [WORD_BITS-1:0] mag_b,
   input  wire logic                 neg,
   output logic [WORD_BITS-1:0]      prod_q_ff
);

   logic [2*WORD_BITS-1:0] prod_ff;
   logic                   neg_ff;
   logic [WORD_BITS-1:0]   rounded;

   assign rounded = prod_ff[WORD_BITS+FRAC_BITS-1:FRAC_BITS]
                  + WORD_BITS'(prod_ff[FRAC_BITS-1]);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= mag_a * mag_b;
         neg_ff    <= neg;
         prod_q_ff <= neg_ff ? (~rounded + 1'b1) : rounded;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/fxa_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
module fxa_div_stage #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           advance,
   input  wire logic [WORD_BITS-1:0]           rem,
   input  wire logic [WORD_BITS+FRAC_BITS-1:0] num,
   input  wire logic [WORD_BITS-1:0]           quo,
   input  wire logic [WORD_BITS-1:0]           den,
   output logic [WORD_BITS-1:0]                rem_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0]      num_ff,
   output logic [WORD_BITS-1:0]                quo_ff,
   output logic [WORD_BITS-1:0]                den_ff
);

   logic [WORD_BITS:0] shifted;
   logic [WORD_BITS:0] diff;
   logic               take;

   assign shifted = {rem, num[WORD_BITS+FRAC_BITS-1]};
   assign diff    = shifted - {1'b0, den};
   assign take    = shifted >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= take ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
         num_ff <= num << 1;
         quo_ff <= {quo[WORD_BITS-2:0], take};
         den_ff <= den;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/fixed_point_alu_q24_8_core.sv */
// signed fixed-point alu, WORD_BITS wide with FRAC_BITS fraction bits
// input channel req_*: command plus two raw operands, one item per cycle
// result channel rsp_*: result value and compare / divide-by-zero flags
// commands: add, sub, mul, div, inc, dec, from_int, to_int, compare;
// mul and div round half away from zero, div by zero returns 0 and flags
// stages: one decode stage, one restoring divide step per quotient
// bit, and the output register; mul runs in parallel in the first
// divide steps; throughput is one item per cycle for every command
// while the receiver keeps rsp_ready high or no result is waiting
// when the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes and req_ready drops; bubbles are not squeezed out
// synchronous reset clears all valid bits, no item is lost or repeated
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8_core import fxa_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_command,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_a_less,
   output logic                    rsp_a_equal,
   output logic                    rsp_a_greater,
   output logic                    rsp_divide_by_zero
);

   localparam int NumSteps = WORD_BITS + FRAC_BITS;

   logic advance;

   logic                           pipe_valid_ff [0:NumSteps];
   cmd_type                        pipe_cmd_ff   [0:NumSteps];
   logic                           pipe_neg_ff   [0:NumSteps];
   logic [WORD_BITS-1:0]           pipe_res_ff   [0:NumSteps];
   flags_type                      pipe_flags_ff [0:NumSteps];

   logic [WORD_BITS-1:0]           div_rem [0:NumSteps];
   logic [NumSteps-1:0]            div_num [0:NumSteps];
   logic [WORD_BITS-1:0]           div_quo [0:NumSteps];
   logic [WORD_BITS-1:0]           div_den [0:NumSteps];

   logic [WORD_BITS-1:0]           mag_a;
   logic [WORD_BITS-1:0]           mul_q;

   logic                           out_valid_ff;
   logic [WORD_BITS-1:0]           out_res_ff;
   logic [WORD_BITS-1:0]           out_res_in;
   flags_type                      out_flags_ff;

   logic [WORD_BITS-1:0]           div_rounded;
   logic                           div_round_up;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   fxa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .command   (req_command),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .valid_ff  (pipe_valid_ff[0]),
      .cmd_ff    (pipe_cmd_ff[0]),
      .neg_ff    (pipe_neg_ff[0]),
      .res_ff    (pipe_res_ff[0]),
      .flags_ff  (pipe_flags_ff[0]),
      .mag_a_ff  (mag_a),
      .mag_b_ff  (div_den[0])
   );

   fxa_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock     (clock),
      .advance   (advance),
      .mag_a     (mag_a),
      .mag_b     (div_den[0]),
      .neg       (pipe_neg_ff[0]),
      .prod_q_ff (mul_q)
   );

   assign div_rem[0] = '0;
   assign div_num[0] = {mag_a, FRAC_BITS'(0)};
   assign div_quo[0] = '0;

   for (genvar k = 0; k < NumSteps; k++) begin : g_step
      fxa_div_stage #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .advance (advance),
         .rem     (div_rem[k]),
         .num     (div_num[k]),
         .quo     (div_quo[k]),
         .den     (div_den[k]),
         .rem_ff  (div_rem[k+1]),
         .num_ff  (div_num[k+1]),
         .quo_ff  (div_quo[k+1]),
         .den_ff  (div_den[k+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            pipe_valid_ff[k+1] <= pipe_valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_cmd_ff[k+1]   <= pipe_cmd_ff[k];
            pipe_neg_ff[k+1]   <= pipe_neg_ff[k];
            pipe_flags_ff[k+1] <= pipe_flags_ff[k];
            if (k == 2 && pipe_cmd_ff[k] == CMD_MUL) begin
               pipe_res_ff[k+1] <= mul_q;
            end else begin
               pipe_res_ff[k+1] <= pipe_res_ff[k];
            end
         end
      end
   end

   assign div_round_up = {div_rem[NumSteps], 1'b0} >= {1'b0, div_den[NumSteps]};
   assign div_rounded  = div_quo[NumSteps] + WORD_BITS'(div_round_up);

   always_comb begin
      out_res_in = pipe_res_ff[NumSteps];
      if (pipe_cmd_ff[NumSteps] == CMD_DIV) begin
         if (pipe_flags_ff[NumSteps].div_zero) begin
            out_res_in = '0;
         end else if (pipe_neg_ff[NumSteps]) begin
            out_res_in = ~div_rounded + 1'b1;
         end else begin
            out_res_in = div_rounded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= pipe_valid_ff[NumSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff   <= out_res_in;
         out_flags_ff <= pipe_flags_ff[NumSteps];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = 32'(signed'(out_res_ff));
   assign rsp_a_less         = out_flags_ff.less;
   assign rsp_a_equal        = out_flags_ff.equal;
   assign rsp_a_greater      = out_flags_ff.greater;
   assign rsp_divide_by_zero = out_flags_ff.div_zero;

endmodule
`default_nettype wire
